// ----- src/cicp_pkg.sv -----
// Package for the cascaded interrupt controller pair.
// Holds command codes, register constants and the structs that the modules share.
// Depends on nothing.
package cicp_pkg;

   localparam logic [2:0] CMD_PORT_WRITE = 3'd0;
   localparam logic [2:0] CMD_PORT_READ  = 3'd1;
   localparam logic [2:0] CMD_RAISE      = 3'd2;
   localparam logic [2:0] CMD_ACK        = 3'd3;
   localparam logic [2:0] CMD_ACK_AUTO   = 3'd4;
   localparam logic [2:0] CMD_EOI        = 3'd5;
   localparam logic [2:0] CMD_QUERY      = 3'd6;

   // Bit positions within a command or data port word.
   localparam int ICW1_BIT      = 4;
   localparam int OCW3_BIT      = 3;
   localparam int OCW3_RR_BIT   = 1;
   localparam int OCW3_RIS_BIT  = 0;
   localparam int ICW1_IC4_BIT  = 0;
   localparam int ICW4_AEOI_BIT = 1;

   // OCW2 forms, taken from the top three bits.
   localparam logic [2:0] OCW2_NS_EOI   = 3'b001;
   localparam logic [2:0] OCW2_SPEC_EOI = 3'b011;
   localparam logic [2:0] OCW2_ROT_EOI  = 3'b101;

   // Initialization sequence steps.
   localparam logic [1:0] STEP_IDLE = 2'd0;
   localparam logic [1:0] STEP_ICW2 = 2'd1;
   localparam logic [1:0] STEP_ICW3 = 2'd2;
   localparam logic [1:0] STEP_ICW4 = 2'd3;

   localparam logic [7:0] CASCADE_BIT    = 8'h04;
   localparam logic [7:0] SLAVE_GATE_ISR = 8'h03;

   localparam logic [7:0] MASTER_MASK_RST = 8'hFC;
   localparam logic [7:0] SLAVE_MASK_RST  = 8'hFF;
   localparam logic [7:0] MASTER_BASE_RST = 8'h08;
   localparam logic [7:0] SLAVE_BASE_RST  = 8'h70;

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] port_select;
      logic [7:0] write_data;
      logic [3:0] irq_line;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       deliverable;
      logic [7:0] vector_number;
   } rsp_item_type;

   // One update for one chip. Port writes and host edits are never both set.
   typedef struct packed {
      logic       cmd_wr;
      logic       data_wr;
      logic [7:0] wdata;
      logic [7:0] req_set;
      logic [7:0] req_clr;
      logic [7:0] isr_set;
      logic [7:0] isr_clr;
   } chip_op_type;

   typedef struct packed {
      logic [7:0] mask;
      logic [7:0] req;
      logic [7:0] isr;
      logic [7:0] base;
      logic       rsel;
      logic       aeoi;
   } chip_stat_type;

endpackage

// ----- src/cicp_req_if.sv -----
// Request channel interface of the cascaded interrupt controller pair.
// Depends on nothing.
interface cicp_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [1:0] port_select;
   logic [7:0] write_data;
   logic [3:0] irq_line;

   modport source (output valid, command, port_select, write_data, irq_line, input ready);
   modport sink (input valid, command, port_select, write_data, irq_line, output ready);
endinterface

// ----- src/cicp_rsp_if.sv -----
// Response channel interface of the cascaded interrupt controller pair.
// Depends on nothing.
interface cicp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       deliverable;
   logic [7:0] vector_number;

   modport source (output valid, read_data, deliverable, vector_number, input ready);
   modport sink (input valid, read_data, deliverable, vector_number, output ready);
endinterface

// ----- src/cascaded_interrupt_controller_pair.sv -----
// Cascaded master/slave interrupt controller pair, top level.
// A word accepted on req_chan is held in the input stage, then its response in the output stage.
// Throughput: one word per cycle, limited only by the response side taking words.
// Reset (synchronous, active high) empties both stages and loads the chip registers
// with their power-up values: masks 0xFC/0xFF, vector bases 0x08/0x70, all else zero.
// Depends on cicp_pkg, cicp_req_if, cicp_rsp_if, cicp_chip and cicp_decode.
module cascaded_interrupt_controller_pair (
   input logic        clock,
   input logic        reset,
   cicp_req_if.sink   req_chan,
   cicp_rsp_if.source rsp_chan
);
   import cicp_pkg::*;

   // The input stage holds one request word. It is decoded against the current
   // chip registers in the cycle it moves on; the chips update at that edge and
   // the response is captured in the output stage at the same edge. Each word
   // therefore sees every effect of the word before it.
   logic         in_valid_ff, in_valid_in;
   req_item_type item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff;

   logic          advance;
   logic          fire;
   logic          req_take;
   chip_stat_type m_stat;
   chip_stat_type s_stat;
   chip_op_type   m_op;
   chip_op_type   s_op;
   rsp_item_type  rsp_next;

   // The output stage frees up when it is empty or its word is being taken.
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign fire     = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.command     <= req_chan.command;
         item_ff.port_select <= req_chan.port_select;
         item_ff.write_data  <= req_chan.write_data;
         item_ff.irq_line    <= req_chan.irq_line;
      end
      if (fire) begin
         out_ff <= rsp_next;
      end
   end

   cicp_decode u_decode (
      .fire   (fire),
      .item   (item_ff),
      .m_stat (m_stat),
      .s_stat (s_stat),
      .m_op   (m_op),
      .s_op   (s_op),
      .rsp    (rsp_next)
   );

   // Master chip: lines 0 to 7; the slave cascades into its line 2.
   cicp_chip #(.SLAVE(1'b0)) u_master (
      .clock (clock),
      .reset (reset),
      .op    (m_op),
      .stat  (m_stat)
   );

   // Slave chip: lines 8 to 15.
   cicp_chip #(.SLAVE(1'b1)) u_slave (
      .clock (clock),
      .reset (reset),
      .op    (s_op),
      .stat  (s_stat)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.read_data     = out_ff.read_data;
   assign rsp_chan.deliverable   = out_ff.deliverable;
   assign rsp_chan.vector_number = out_ff.vector_number;

   // A word stuck behind a stalled response stays in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input stage lost a word while the response side stalled");

   // A response appears only when a request word was waiting to be decoded.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("response word raised without a request word");

   // Acknowledging a slave line marks the cascade input in service on the master.
   assert property (@(posedge clock) disable iff (reset)
      fire && item_ff.command == CMD_ACK && item_ff.irq_line[3] && !m_stat.aeoi
      |=> m_stat.isr[2])
      else $error("slave acknowledge did not set master cascade in-service bit");

endmodule

// ----- src/cicp_chip.sv -----
// Register set of one interrupt controller chip and its update logic.
// Depends on cicp_pkg.
module cicp_chip #(
   parameter logic SLAVE = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cicp_pkg::chip_op_type   op,
   output cicp_pkg::chip_stat_type stat
);
   import cicp_pkg::*;

   logic [7:0] mask_ff, mask_in;
   logic [7:0] req_ff, req_in;
   logic [7:0] isr_ff, isr_in;
   logic [7:0] base_ff, base_in;
   logic [1:0] step_ff, step_in;
   logic       f4_ff, f4_in;
   logic       rsel_ff, rsel_in;
   logic       aeoi_ff, aeoi_in;

   always_comb begin
      mask_in = mask_ff;
      req_in  = req_ff;
      isr_in  = isr_ff;
      base_in = base_ff;
      step_in = step_ff;
      f4_in   = f4_ff;
      rsel_in = rsel_ff;
      aeoi_in = aeoi_ff;
      if (op.cmd_wr) begin
         if (op.wdata[ICW1_BIT]) begin
            step_in = STEP_ICW2;
            f4_in   = op.wdata[ICW1_IC4_BIT];
            isr_in  = '0;
            req_in  = '0;
            mask_in = '0;
         end else if (op.wdata[OCW3_BIT]) begin
            if (op.wdata[OCW3_RR_BIT]) begin
               rsel_in = op.wdata[OCW3_RIS_BIT];
            end
         end else begin
            case (op.wdata[7:5])
               OCW2_NS_EOI, OCW2_ROT_EOI: begin
                  // Clearing the lowest set bit: x & (x - 1).
                  isr_in = isr_ff & (isr_ff - 8'd1);
               end
               OCW2_SPEC_EOI: begin
                  isr_in = isr_ff & ~(8'd1 << op.wdata[2:0]);
               end
               default: begin
               end
            endcase
         end
      end else if (op.data_wr) begin
         case (step_ff)
            STEP_ICW2: begin
               base_in = op.wdata;
               step_in = STEP_ICW3;
            end
            STEP_ICW3: begin
               step_in = f4_ff ? STEP_ICW4 : STEP_IDLE;
            end
            STEP_ICW4: begin
               aeoi_in = op.wdata[ICW4_AEOI_BIT];
               step_in = STEP_IDLE;
            end
            default: begin
               mask_in = op.wdata;
            end
         endcase
      end else begin
         req_in = (req_ff | op.req_set) & ~op.req_clr;
         isr_in = (isr_ff | op.isr_set) & ~op.isr_clr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= SLAVE ? SLAVE_MASK_RST : MASTER_MASK_RST;
         base_ff <= SLAVE ? SLAVE_BASE_RST : MASTER_BASE_RST;
         req_ff  <= '0;
         isr_ff  <= '0;
         step_ff <= STEP_IDLE;
         f4_ff   <= 1'b0;
         rsel_ff <= 1'b0;
         aeoi_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         base_ff <= base_in;
         req_ff  <= req_in;
         isr_ff  <= isr_in;
         step_ff <= step_in;
         f4_ff   <= f4_in;
         rsel_ff <= rsel_in;
         aeoi_ff <= aeoi_in;
      end
   end

   assign stat.mask = mask_ff;
   assign stat.req  = req_ff;
   assign stat.isr  = isr_ff;
   assign stat.base = base_ff;
   assign stat.rsel = rsel_ff;
   assign stat.aeoi = aeoi_ff;

endmodule

// ----- src/cicp_decode.sv -----
// Command decode: turns one request word into per-chip updates and a response word.
// Depends on cicp_pkg.
module cicp_decode (
   input  logic                    fire,
   input  cicp_pkg::req_item_type  item,
   input  cicp_pkg::chip_stat_type m_stat,
   input  cicp_pkg::chip_stat_type s_stat,
   output cicp_pkg::chip_op_type   m_op,
   output cicp_pkg::chip_op_type   s_op,
   output cicp_pkg::rsp_item_type  rsp
);
   import cicp_pkg::*;

   logic          line_chip;
   logic [2:0]    line_idx;
   logic [7:0]    line_bit;
   logic [7:0]    prio_mask;
   logic [7:0]    slave_rest;
   chip_stat_type p_stat;
   chip_stat_type l_stat;

   always_comb begin
      line_chip  = item.irq_line[3];
      line_idx   = item.irq_line[2:0];
      line_bit   = 8'd1 << line_idx;
      // The line itself and every line of higher priority.
      prio_mask  = 8'hFF >> (3'd7 - line_idx);
      slave_rest = s_stat.isr & ~line_bit;
      p_stat     = item.port_select[1] ? s_stat : m_stat;
      l_stat     = line_chip ? s_stat : m_stat;

      m_op = '0;
      s_op = '0;
      rsp  = '0;

      case (item.command)
         CMD_PORT_WRITE: begin
            if (item.port_select[1]) begin
               s_op.cmd_wr  = ~item.port_select[0];
               s_op.data_wr = item.port_select[0];
               s_op.wdata   = item.write_data;
            end else begin
               m_op.cmd_wr  = ~item.port_select[0];
               m_op.data_wr = item.port_select[0];
               m_op.wdata   = item.write_data;
            end
         end
         CMD_PORT_READ: begin
            if (item.port_select[0]) begin
               rsp.read_data = p_stat.mask;
            end else begin
               rsp.read_data = p_stat.rsel ? p_stat.isr : p_stat.req;
            end
         end
         CMD_RAISE: begin
            if (line_chip) begin
               s_op.req_set = line_bit;
            end else begin
               m_op.req_set = line_bit;
            end
         end
         CMD_ACK: begin
            if (line_chip) begin
               s_op.req_clr = line_bit;
               s_op.isr_set = s_stat.aeoi ? 8'h00 : line_bit;
               m_op.isr_set = m_stat.aeoi ? 8'h00 : CASCADE_BIT;
            end else begin
               m_op.req_clr = line_bit;
               m_op.isr_set = m_stat.aeoi ? 8'h00 : line_bit;
            end
         end
         CMD_ACK_AUTO: begin
            if (line_chip) begin
               // Acknowledge then end of interrupt: the slave bit ends up clear.
               s_op.req_clr = line_bit;
               s_op.isr_clr = line_bit;
               m_op.isr_set = m_stat.aeoi ? 8'h00 : CASCADE_BIT;
               m_op.isr_clr = (slave_rest == 8'h00) ? CASCADE_BIT : 8'h00;
            end else begin
               m_op.req_clr = line_bit;
            end
         end
         CMD_EOI: begin
            if (line_chip) begin
               s_op.isr_clr = line_bit;
               m_op.isr_clr = (slave_rest == 8'h00) ? CASCADE_BIT : 8'h00;
            end else begin
               m_op.isr_clr = line_bit;
            end
         end
         CMD_QUERY: begin
            rsp.deliverable = ((l_stat.mask & line_bit) == 8'h00)
                           && ((l_stat.isr & prio_mask) == 8'h00)
                           && (!line_chip
                               || (((m_stat.mask & CASCADE_BIT) == 8'h00)
                                   && ((m_stat.isr & SLAVE_GATE_ISR) == 8'h00)));
            rsp.vector_number = l_stat.base + {5'd0, line_idx};
         end
         default: begin
         end
      endcase

      if (!fire) begin
         m_op = '0;
         s_op = '0;
      end
   end

endmodule
